/* rtl/core/dfap_pkg.sv */
// dfap_pkg: operation codes, register offsets and bit masks of the DAC FIFO audio port.
// No dependencies; used by dac_fifo_audio_port_unit.
`timescale 1ns / 1ps

package dfap_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] PORT_ADC      = 3'd0;
  localparam logic [2:0] PORT_UNUSED   = 3'd1;
  localparam logic [2:0] PORT_CTRL     = 3'd2;
  localparam logic [2:0] PORT_TIMER    = 3'd3;
  localparam logic [2:0] PORT_LOW_MARK = 3'd4;

  localparam logic [7:0] ST_ALMOST_EMPTY = 8'h02;
  localparam logic [7:0] ST_ADC_READY    = 8'h10;
  localparam logic [7:0] IRQ_SOURCES     = 8'h12;
  localparam logic [7:0] CTRL_IRQ_EN     = 8'h01;
  localparam logic [7:0] RD_FULL         = 8'h08;
  localparam logic [7:0] RD_EMPTY        = 8'h04;
  localparam logic [7:0] RD_IDLE         = 8'hff;
  localparam logic [7:0] SIGN_FLIP       = 8'h80;

  localparam int LOW_MARK_W = 10;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] port;
  } dfap_cmd_t;

endpackage

/* rtl/core/dfap_sample_ram.sv */
// dfap_sample_ram: single-port-write, registered-read sample store of the FIFO.
// No dependencies; instantiated by dac_fifo_audio_port_unit.
`timescale 1ns / 1ps

module dfap_sample_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/dac_fifo_audio_port_unit.sv */
// dac_fifo_audio_port_unit: register window, FIFO pointers, interval timer and DAC latch.
// Depends on dfap_pkg and dfap_sample_ram.
`timescale 1ns / 1ps

// A command is accepted when start is high and busy low; the
// registers and FIFO pointers update at that edge while the sample store is read at the
// read pointer, and in the next cycle the result (read data, irq, DAC sample) is latched
// and shown for one cycle with out_valid; busy is high only while it is latched, so a
// new command may be started while the result is on the ports. The receiver cannot stall.
// The sample store needs no clearing after reset.

module dac_fifo_audio_port_unit #(
  parameter int FIFO_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [2:0]         in_port,
  input  logic [7:0]         in_write_data,
  output logic               out_valid,
  output logic [7:0]         out_read_data,
  output logic               out_irq,
  output logic signed [12:0] out_dac_sample
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int PW = $clog2(2 * FIFO_DEPTH);
  localparam logic [PW-1:0] DEPTH_P     = PW'(FIFO_DEPTH);
  localparam logic [PW-1:0] SPAN_P      = PW'(2 * FIFO_DEPTH);
  localparam logic [PW-1:0] PTR_LAST    = PW'(2 * FIFO_DEPTH - 1);
  localparam logic [PW-1:0] PTR_ONE     = PW'(1);

  typedef enum logic {S_IDLE, S_DONE} state_t;

  state_t state_r;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [7:0] status_r, status_nxt, ctrl_r, ctrl_nxt, reload_r, reload_nxt;
  logic [7:0] count_r, count_nxt, dac_r, dac_nxt, rd_r, rd_nxt;
  logic running_r, running_nxt, pop_r, pop_nxt;
  logic [dfap_pkg::LOW_MARK_W-1:0] mark_r, mark_nxt;
  logic out_valid_r, out_irq_r;
  logic [7:0] out_read_data_r;
  logic signed [12:0] out_dac_r;

  dfap_pkg::dfap_cmd_t cmd;
  logic accept;
  logic [PW-1:0] fill, fill_after;
  logic full, empty, expire;
  logic [AW-1:0] wr_slot, rd_slot;
  logic wr_en;
  logic [7:0] ram_rdata;
  logic [7:0] dac_flip;

  assign cmd.op   = in_operation;
  assign cmd.port = in_port;
  assign busy   = (state_r == S_DONE);
  assign accept = start && !busy;

  assign fill  = (wp_r >= rp_r) ? wp_r - rp_r : wp_r - rp_r + SPAN_P;
  assign full  = (fill >= DEPTH_P);
  assign empty = (fill == '0);
  assign wr_slot = (wp_r >= DEPTH_P) ? AW'(wp_r - DEPTH_P) : AW'(wp_r);
  assign rd_slot = (rp_r >= DEPTH_P) ? AW'(rp_r - DEPTH_P) : AW'(rp_r);
  assign expire = (count_r <= 8'd1);
  assign wr_en  = accept && (cmd.op == dfap_pkg::OP_WRITE) &&
                  (cmd.port == dfap_pkg::PORT_ADC) && !full;

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    status_nxt  = status_r;
    ctrl_nxt    = ctrl_r;
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    running_nxt = running_r;
    mark_nxt    = mark_r;
    rd_nxt      = dfap_pkg::RD_IDLE;
    pop_nxt     = 1'b0;
    fill_after  = fill;
    unique case (cmd.op)
      dfap_pkg::OP_READ: begin
        unique case (cmd.port)
          dfap_pkg::PORT_ADC: begin
            status_nxt = status_r & ~dfap_pkg::ST_ADC_READY;
            rd_nxt     = 8'h00;
          end
          dfap_pkg::PORT_UNUSED: rd_nxt = dfap_pkg::RD_IDLE;
          dfap_pkg::PORT_CTRL: begin
            rd_nxt = status_r | (ctrl_r & dfap_pkg::CTRL_IRQ_EN) |
                     (full ? dfap_pkg::RD_FULL : 8'h00) |
                     (empty ? dfap_pkg::RD_EMPTY : 8'h00);
          end
          dfap_pkg::PORT_TIMER: rd_nxt = reload_r;
          default: rd_nxt = 8'h00;
        endcase
      end
      dfap_pkg::OP_WRITE: begin
        unique case (cmd.port)
          dfap_pkg::PORT_ADC: begin
            if (!full) begin
              wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_ONE;
            end
          end
          dfap_pkg::PORT_CTRL: begin
            ctrl_nxt = in_write_data;
            if ((in_write_data & dfap_pkg::ST_ALMOST_EMPTY) == 8'h00) begin
              status_nxt = status_r & ~dfap_pkg::ST_ALMOST_EMPTY;
            end
          end
          dfap_pkg::PORT_TIMER: begin
            reload_nxt  = in_write_data;
            count_nxt   = 8'hff - in_write_data;
            running_nxt = (in_write_data != 8'h00);
          end
          dfap_pkg::PORT_LOW_MARK: mark_nxt = {in_write_data, 2'b00};
          default: ;
        endcase
      end
      dfap_pkg::OP_TICK: begin
        if (running_r) begin
          if (expire) begin
            if (!empty) begin
              pop_nxt    = 1'b1;
              rp_nxt     = (rp_r == PTR_LAST) ? '0 : rp_r + PTR_ONE;
              fill_after = fill - PTR_ONE;
            end
            status_nxt = status_r | dfap_pkg::ST_ADC_READY |
                         ((fill_after == PW'(mark_r)) ? dfap_pkg::ST_ALMOST_EMPTY : 8'h00);
            if (count_r == 8'd1) begin
              count_nxt = reload_r;
            end else begin
              count_nxt = (reload_r == 8'h00) ? 8'h00 : reload_r - 8'd1;
            end
          end else begin
            count_nxt = count_r - 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign dac_nxt  = pop_r ? ram_rdata : dac_r;
  assign dac_flip = dac_nxt ^ dfap_pkg::SIGN_FLIP;

  dfap_sample_ram #(
    .DEPTH(FIFO_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_slot),
    .wr_data(in_write_data),
    .rd_en  (accept),
    .rd_addr(rd_slot),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      status_r    <= '0;
      ctrl_r      <= '0;
      reload_r    <= '0;
      count_r     <= '0;
      running_r   <= 1'b0;
      mark_r      <= '0;
      dac_r       <= '0;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (accept) begin
            wp_r      <= wp_nxt;
            rp_r      <= rp_nxt;
            status_r  <= status_nxt;
            ctrl_r    <= ctrl_nxt;
            reload_r  <= reload_nxt;
            count_r   <= count_nxt;
            running_r <= running_nxt;
            mark_r    <= mark_nxt;
            pop_r     <= pop_nxt;
            rd_r      <= rd_nxt;
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          dac_r           <= dac_nxt;
          pop_r           <= 1'b0;
          out_valid_r     <= 1'b1;
          out_read_data_r <= rd_r;
          out_irq_r       <= ((status_r & ctrl_r & dfap_pkg::IRQ_SOURCES) != 8'h00) &&
                             ((ctrl_r & dfap_pkg::CTRL_IRQ_EN) != 8'h00);
          out_dac_r       <= signed'({dac_flip, 5'b00000});
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_irq        = out_irq_r;
  assign out_dac_sample = out_dac_r;

endmodule
